FILE: sv/quaternion_axis_angle_rotate_core_macros.svh
// Assertion helpers for the quaternion rotate core.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef QUATERNION_AXIS_ANGLE_ROTATE_CORE_MACROS_SVH
`define QUATERNION_AXIS_ANGLE_ROTATE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define QAAR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("quaternion rotate core: check failed");
// Next-cycle implication.
`define QAAR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("quaternion rotate core: check failed");
`else
`define QAAR_ASSERT_IMP(lbl, ante, cons)
`define QAAR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: sv/qaar_pkg.sv
package qaar_pkg;

  // Component format and CORDIC depth.
  localparam int COMP_WIDTH    = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int FRAC_BITS     = COMP_WIDTH - 2;
  localparam int ANGLE_W       = 16;

  // The half angle lives in a 32-bit phase: angle shifted up by this much.
  localparam int PHASE_SH  = 15;
  localparam int Q30       = 30;
  localparam int ROUND_SH  = Q30 - FRAC_BITS;

  // CORDIC datapath widths (Q4.30 vector, 2^32-per-turn residual angle).
  localparam int XY_W      = 34;
  localparam int Z_W       = 33;
  localparam int IDX_W     = $clog2(CORDIC_STAGES);
  localparam int TAB_IDX_W = 5;

  // Rounded sin/cos, axis products, Hamilton products and their sums.
  localparam int CS_W  = XY_W - ROUND_SH;
  localparam int AP_W  = CS_W + COMP_WIDTH;
  localparam int HP_W  = CS_W + COMP_WIDTH;
  localparam int HS_W  = HP_W + 2;
  localparam int RND_W = HS_W - FRAC_BITS;

  typedef logic signed [COMP_WIDTH-1:0] comp_t;
  typedef logic signed [CS_W-1:0]       cs_t;
  typedef logic signed [XY_W-1:0]       xy_t;
  typedef logic signed [Z_W-1:0]        z_t;

  localparam comp_t COMP_MAX  = {1'b0, {(COMP_WIDTH-1){1'b1}}};
  localparam comp_t COMP_MIN  = {1'b1, {(COMP_WIDTH-1){1'b0}}};
  localparam xy_t   GAIN_Q30  = XY_W'(652032874);

  typedef struct packed {
    comp_t                quat_w;
    comp_t                quat_x;
    comp_t                quat_y;
    comp_t                quat_z;
    logic [ANGLE_W-1:0]   turn_angle;
    comp_t                axis_x;
    comp_t                axis_y;
    comp_t                axis_z;
  } qaar_in_t;

  typedef struct packed {
    comp_t res_w;
    comp_t res_x;
    comp_t res_y;
    comp_t res_z;
    logic  clipped;
  } qaar_out_t;

  // Operands that ride alongside the CORDIC vector.
  typedef struct packed {
    comp_t quat_w;
    comp_t quat_x;
    comp_t quat_y;
    comp_t quat_z;
    comp_t axis_x;
    comp_t axis_y;
    comp_t axis_z;
    logic  upper;
  } qaar_carry_t;

  typedef struct packed {
    xy_t         x;
    xy_t         y;
    z_t          z;
    qaar_carry_t carry;
  } qaar_cord_t;

  // Input quaternion together with the finished rotation quaternion.
  typedef struct packed {
    comp_t quat_w;
    comp_t quat_x;
    comp_t quat_y;
    comp_t quat_z;
    cs_t   rot_w;
    comp_t rot_x;
    comp_t rot_y;
    comp_t rot_z;
  } qaar_rq_t;

  typedef struct packed {
    logic  hit;
    comp_t val;
  } qaar_sat_t;

  // Arctangent of 2^-i, with 2^32 per turn.
  function automatic z_t atan_turn(input logic [TAB_IDX_W-1:0] idx);
    z_t ang;
    unique case (idx)
      5'd0:    ang = Z_W'(536870912);
      5'd1:    ang = Z_W'(316933406);
      5'd2:    ang = Z_W'(167458907);
      5'd3:    ang = Z_W'(85004756);
      5'd4:    ang = Z_W'(42667331);
      5'd5:    ang = Z_W'(21354465);
      5'd6:    ang = Z_W'(10679838);
      5'd7:    ang = Z_W'(5340245);
      5'd8:    ang = Z_W'(2670163);
      5'd9:    ang = Z_W'(1335087);
      5'd10:   ang = Z_W'(667544);
      5'd11:   ang = Z_W'(333772);
      5'd12:   ang = Z_W'(166886);
      5'd13:   ang = Z_W'(83443);
      5'd14:   ang = Z_W'(41722);
      5'd15:   ang = Z_W'(20861);
      5'd16:   ang = Z_W'(10430);
      5'd17:   ang = Z_W'(5215);
      5'd18:   ang = Z_W'(2608);
      5'd19:   ang = Z_W'(1304);
      5'd20:   ang = Z_W'(652);
      5'd21:   ang = Z_W'(326);
      5'd22:   ang = Z_W'(163);
      5'd23:   ang = Z_W'(81);
      5'd24:   ang = Z_W'(41);
      5'd25:   ang = Z_W'(20);
      5'd26:   ang = Z_W'(10);
      5'd27:   ang = Z_W'(5);
      5'd28:   ang = Z_W'(3);
      5'd29:   ang = Z_W'(1);
      default: ang = '0;
    endcase
    return ang;
  endfunction

  // Clamp a rounded value to the component range and flag the clamp.
  function automatic qaar_sat_t sat_comp(input logic signed [RND_W-1:0] v);
    qaar_sat_t res;
    if (v > RND_W'(COMP_MAX)) begin
      res.hit = 1'b1;
      res.val = COMP_MAX;
    end else if (v < RND_W'(COMP_MIN)) begin
      res.hit = 1'b1;
      res.val = COMP_MIN;
    end else begin
      res.hit = 1'b0;
      res.val = v[COMP_WIDTH-1:0];
    end
    return res;
  endfunction

endpackage

FILE: sv/qaar_cordic_cell.sv
module qaar_cordic_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [qaar_pkg::IDX_W-1:0] stage_idx,
  input  logic                     vld_in,
  output logic                     hold_out,
  input  qaar_pkg::qaar_cord_t     data_in,
  output logic                     vld_out,
  input  logic                     hold_in,
  output qaar_pkg::qaar_cord_t     data_out
);
  import qaar_pkg::*;

  logic       take;
  logic       vld_r;
  qaar_cord_t cord_r;
  qaar_cord_t cord_nxt;
  xy_t        dx;
  xy_t        dy;
  z_t         ang;

  // The cell loads whenever it is empty or its beat moves on downstream.
  assign take     = !vld_r || !hold_in;
  assign hold_out = !take;
  assign vld_out  = vld_r;
  assign data_out = cord_r;

  // One micro-rotation; the sign of the residual angle picks the direction.
  always_comb begin
    dx       = $signed(data_in.y) >>> stage_idx;
    dy       = $signed(data_in.x) >>> stage_idx;
    ang      = atan_turn(TAB_IDX_W'(stage_idx));
    cord_nxt = data_in;
    if (!data_in.z[Z_W-1]) begin
      cord_nxt.x = data_in.x - dx;
      cord_nxt.y = data_in.y + dy;
      cord_nxt.z = data_in.z - ang;
    end else begin
      cord_nxt.x = data_in.x + dx;
      cord_nxt.y = data_in.y - dy;
      cord_nxt.z = data_in.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (take) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (take && vld_in) begin
      cord_r <= cord_nxt;
    end
  end

endmodule

FILE: sv/qaar_rot_build.sv
module qaar_rot_build (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 vld_in,
  output logic                 hold_out,
  input  qaar_pkg::qaar_cord_t data_in,
  output logic                 vld_out,
  input  logic                 hold_in,
  output qaar_pkg::qaar_rq_t   data_out
);
  import qaar_pkg::*;

  logic                    take1;
  logic                    take2;
  logic                    take3;
  logic                    s1_vld_r;
  logic                    s2_vld_r;
  logic                    s3_vld_r;

  xy_t                     c_pre;
  xy_t                     s_pre;
  xy_t                     c_sum;
  xy_t                     s_sum;
  cs_t                     c_nxt;
  cs_t                     s_nxt;
  cs_t                     s1_c_r;
  cs_t                     s1_s_r;
  qaar_carry_t             s1_car_r;

  logic signed [AP_W-1:0]  px_nxt;
  logic signed [AP_W-1:0]  py_nxt;
  logic signed [AP_W-1:0]  pz_nxt;
  logic signed [AP_W-1:0]  s2_px_r;
  logic signed [AP_W-1:0]  s2_py_r;
  logic signed [AP_W-1:0]  s2_pz_r;
  cs_t                     s2_c_r;
  qaar_carry_t             s2_car_r;

  logic signed [AP_W-1:0]  rx_sum;
  logic signed [AP_W-1:0]  ry_sum;
  logic signed [AP_W-1:0]  rz_sum;
  qaar_sat_t               rx_sat;
  qaar_sat_t               ry_sat;
  qaar_sat_t               rz_sat;
  qaar_rq_t                rq_nxt;
  qaar_rq_t                rq_r;

  // Three-stage pipe; each stage loads when empty or when the next one loads.
  assign take3    = !s3_vld_r || !hold_in;
  assign take2    = !s2_vld_r || take3;
  assign take1    = !s1_vld_r || take2;
  assign hold_out = !take1;
  assign vld_out  = s3_vld_r;
  assign data_out = rq_r;

  // Quadrant fix-up, then round cos and sin from Q4.30 to the component format.
  always_comb begin
    if (data_in.carry.upper) begin
      c_pre = -data_in.y;
      s_pre = data_in.x;
    end else begin
      c_pre = data_in.x;
      s_pre = data_in.y;
    end
    c_sum = c_pre + XY_W'(2 ** (ROUND_SH - 1));
    s_sum = s_pre + XY_W'(2 ** (ROUND_SH - 1));
    c_nxt = c_sum[XY_W-1:ROUND_SH];
    s_nxt = s_sum[XY_W-1:ROUND_SH];
  end

  // Scale the axis by the sine.
  always_comb begin
    px_nxt = AP_W'(s1_s_r) * AP_W'($signed(s1_car_r.axis_x));
    py_nxt = AP_W'(s1_s_r) * AP_W'($signed(s1_car_r.axis_y));
    pz_nxt = AP_W'(s1_s_r) * AP_W'($signed(s1_car_r.axis_z));
  end

  // Round the vector part and clamp it; this clamp is not reported.
  always_comb begin
    rx_sum = s2_px_r + AP_W'(2 ** (FRAC_BITS - 1));
    ry_sum = s2_py_r + AP_W'(2 ** (FRAC_BITS - 1));
    rz_sum = s2_pz_r + AP_W'(2 ** (FRAC_BITS - 1));
    rx_sat = sat_comp(RND_W'($signed(rx_sum[AP_W-1:FRAC_BITS])));
    ry_sat = sat_comp(RND_W'($signed(ry_sum[AP_W-1:FRAC_BITS])));
    rz_sat = sat_comp(RND_W'($signed(rz_sum[AP_W-1:FRAC_BITS])));
    rq_nxt.quat_w = s2_car_r.quat_w;
    rq_nxt.quat_x = s2_car_r.quat_x;
    rq_nxt.quat_y = s2_car_r.quat_y;
    rq_nxt.quat_z = s2_car_r.quat_z;
    rq_nxt.rot_w  = s2_c_r;
    rq_nxt.rot_x  = rx_sat.val;
    rq_nxt.rot_y  = ry_sat.val;
    rq_nxt.rot_z  = rz_sat.val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      if (take1) begin
        s1_vld_r <= vld_in;
      end
      if (take2) begin
        s2_vld_r <= s1_vld_r;
      end
      if (take3) begin
        s3_vld_r <= s2_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take1 && vld_in) begin
      s1_c_r   <= c_nxt;
      s1_s_r   <= s_nxt;
      s1_car_r <= data_in.carry;
    end
    if (take2 && s1_vld_r) begin
      s2_px_r  <= px_nxt;
      s2_py_r  <= py_nxt;
      s2_pz_r  <= pz_nxt;
      s2_c_r   <= s1_c_r;
      s2_car_r <= s1_car_r;
    end
    if (take3 && s2_vld_r) begin
      rq_r     <= rq_nxt;
    end
  end

endmodule

FILE: sv/qaar_hamilton.sv
module qaar_hamilton (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                vld_in,
  output logic                hold_out,
  input  qaar_pkg::qaar_rq_t  data_in,
  output logic                vld_out,
  input  logic                hold_in,
  output qaar_pkg::qaar_out_t data_out
);
  import qaar_pkg::*;

  logic                    take1;
  logic                    take2;
  logic                    take3;
  logic                    s1_vld_r;
  logic                    s2_vld_r;
  logic                    s3_vld_r;

  logic signed [HP_W-1:0]  qw;
  logic signed [HP_W-1:0]  qx;
  logic signed [HP_W-1:0]  qy;
  logic signed [HP_W-1:0]  qz;
  logic signed [HP_W-1:0]  rw;
  logic signed [HP_W-1:0]  rx;
  logic signed [HP_W-1:0]  ry;
  logic signed [HP_W-1:0]  rz;
  logic signed [HP_W-1:0]  hp_nxt [4][4];
  logic signed [HP_W-1:0]  hp_r [4][4];

  logic signed [HS_W-1:0]  sum_nxt [4];
  logic signed [HS_W-1:0]  sum_r [4];

  logic signed [HS_W-1:0]  rnd [4];
  qaar_sat_t               sat [4];
  qaar_out_t               out_nxt;
  qaar_out_t               out_r;

  // Three-stage pipe with the output register as its last stage.
  assign take3    = !s3_vld_r || !hold_in;
  assign take2    = !s2_vld_r || take3;
  assign take1    = !s1_vld_r || take2;
  assign hold_out = !take1;
  assign vld_out  = s3_vld_r;
  assign data_out = out_r;

  // The sixteen partial products of q * r, grouped by result part.
  always_comb begin
    qw = HP_W'($signed(data_in.quat_w));
    qx = HP_W'($signed(data_in.quat_x));
    qy = HP_W'($signed(data_in.quat_y));
    qz = HP_W'($signed(data_in.quat_z));
    rw = HP_W'($signed(data_in.rot_w));
    rx = HP_W'($signed(data_in.rot_x));
    ry = HP_W'($signed(data_in.rot_y));
    rz = HP_W'($signed(data_in.rot_z));
    hp_nxt[0][0] = qw * rw;
    hp_nxt[0][1] = qx * rx;
    hp_nxt[0][2] = qy * ry;
    hp_nxt[0][3] = qz * rz;
    hp_nxt[1][0] = qw * rx;
    hp_nxt[1][1] = qx * rw;
    hp_nxt[1][2] = qy * rz;
    hp_nxt[1][3] = qz * ry;
    hp_nxt[2][0] = qw * ry;
    hp_nxt[2][1] = qy * rw;
    hp_nxt[2][2] = qz * rx;
    hp_nxt[2][3] = qx * rz;
    hp_nxt[3][0] = qw * rz;
    hp_nxt[3][1] = qz * rw;
    hp_nxt[3][2] = qx * ry;
    hp_nxt[3][3] = qy * rx;
  end

  // Exact sums; the scalar part subtracts the three vector dot terms.
  always_comb begin
    sum_nxt[0] = HS_W'(hp_r[0][0]) - HS_W'(hp_r[0][1])
               - HS_W'(hp_r[0][2]) - HS_W'(hp_r[0][3]);
    for (int k = 1; k < 4; k++) begin
      sum_nxt[k] = HS_W'(hp_r[k][0]) + HS_W'(hp_r[k][1])
                 + HS_W'(hp_r[k][2]) - HS_W'(hp_r[k][3]);
    end
  end

  // Round half up, saturate, and flag any clamp.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rnd[k] = sum_r[k] + HS_W'(2 ** (FRAC_BITS - 1));
      sat[k] = sat_comp(rnd[k][HS_W-1:FRAC_BITS]);
    end
    out_nxt.res_w   = sat[0].val;
    out_nxt.res_x   = sat[1].val;
    out_nxt.res_y   = sat[2].val;
    out_nxt.res_z   = sat[3].val;
    out_nxt.clipped = sat[0].hit || sat[1].hit || sat[2].hit || sat[3].hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      if (take1) begin
        s1_vld_r <= vld_in;
      end
      if (take2) begin
        s2_vld_r <= s1_vld_r;
      end
      if (take3) begin
        s3_vld_r <= s2_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take1 && vld_in) begin
      hp_r <= hp_nxt;
    end
    if (take2 && s1_vld_r) begin
      sum_r <= sum_nxt;
    end
    if (take3 && s2_vld_r) begin
      out_r <= out_nxt;
    end
  end

endmodule

FILE: sv/quaternion_axis_angle_rotate_core.sv
// An accepted input beat passes through registered stages to its result beat
// (16 CORDIC cells, 3 rotation-quaternion stages, 3 product stages).
// Throughput: one beat per cycle; every stage is a register with its own valid.
// A stalled output stops only the full stages behind it; bubbles still close up.
// Reset is synchronous and active low and clears the valid bits only.
`include "quaternion_axis_angle_rotate_core_macros.svh"
module quaternion_axis_angle_rotate_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  qaar_pkg::qaar_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output qaar_pkg::qaar_out_t out_data
);
  import qaar_pkg::*;

  logic       cv [CORDIC_STAGES+1];
  logic       ch [CORDIC_STAGES+1];
  qaar_cord_t cd [CORDIC_STAGES+1];
  logic       rq_vld;
  logic       rq_hold;
  qaar_rq_t   rq_data;

  // Fold the half-angle phase into the first quarter turn and seed the vector.
  always_comb begin
    cd[0].x            = GAIN_Q30;
    cd[0].y            = '0;
    cd[0].z            = Z_W'({in_data.turn_angle[ANGLE_W-2:0], {PHASE_SH{1'b0}}});
    cd[0].carry.quat_w = in_data.quat_w;
    cd[0].carry.quat_x = in_data.quat_x;
    cd[0].carry.quat_y = in_data.quat_y;
    cd[0].carry.quat_z = in_data.quat_z;
    cd[0].carry.axis_x = in_data.axis_x;
    cd[0].carry.axis_y = in_data.axis_y;
    cd[0].carry.axis_z = in_data.axis_z;
    cd[0].carry.upper  = in_data.turn_angle[ANGLE_W-1];
  end

  assign cv[0]    = in_valid;
  assign in_stall = ch[0];

  // Row of CORDIC cells, one micro-rotation each.
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    qaar_cordic_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_idx (IDX_W'(g)),
      .vld_in    (cv[g]),
      .hold_out  (ch[g]),
      .data_in   (cd[g]),
      .vld_out   (cv[g+1]),
      .hold_in   (ch[g+1]),
      .data_out  (cd[g+1])
    );
  end

  // Rotation quaternion from sin, cos and the axis.
  qaar_rot_build u_rot (
    .clk      (clk),
    .rst_n    (rst_n),
    .vld_in   (cv[CORDIC_STAGES]),
    .hold_out (ch[CORDIC_STAGES]),
    .data_in  (cd[CORDIC_STAGES]),
    .vld_out  (rq_vld),
    .hold_in  (rq_hold),
    .data_out (rq_data)
  );

  // Hamilton product, rounding and saturation.
  qaar_hamilton u_ham (
    .clk      (clk),
    .rst_n    (rst_n),
    .vld_in   (rq_vld),
    .hold_out (rq_hold),
    .data_in  (rq_data),
    .vld_out  (out_valid),
    .hold_in  (out_stall),
    .data_out (out_data)
  );

  // The input side can only back up when the result beat is held.
  `QAAR_ASSERT_IMP(a_stall_needs_held_out, in_stall, out_valid && out_stall)
  // A full pipe never drops the waiting result.
  `QAAR_ASSERT_NXT(a_full_pipe_keeps_beat, in_stall, out_valid)
  // A clipped result has at least one part on a rail.
  `QAAR_ASSERT_IMP(a_clip_on_rail, out_valid && out_data.clipped,
    out_data.res_w == COMP_MAX || out_data.res_w == COMP_MIN ||
    out_data.res_x == COMP_MAX || out_data.res_x == COMP_MIN ||
    out_data.res_y == COMP_MAX || out_data.res_y == COMP_MIN ||
    out_data.res_z == COMP_MAX || out_data.res_z == COMP_MIN)

endmodule
